FILE: hw/rtl/rrss_pkg.sv
// ----------------------------------------------------------------------------
// rrss_pkg
// shared constants for the round-robin schedule simulator
// ----------------------------------------------------------------------------
package rrss_pkg;
    localparam int MAX_JOBS_DEF = 32;
    localparam int TIME_W       = 16;
    localparam int CLK_W        = 24;
    localparam int JOBNUM_W     = 7;
    localparam logic [TIME_W-1:0] QUANTUM_RST = 16'd4;

    // per-job scheduling phase
    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_QUEUED = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;
endpackage

FILE: hw/rtl/round_robin_schedule_simulator.sv
// ----------------------------------------------------------------------------
// round_robin_schedule_simulator
// round-robin time slicing over a loaded batch of jobs
// ----------------------------------------------------------------------------
// Each request without last_job is stored while the batch holds fewer than
// MAX_JOBS jobs. A request with last_job starts the simulation over the n
// loaded jobs: every scheduling turn scans all loaded jobs for arrivals
// through the job memories, whose read data is registered. An idle tick
// advances the simulated clock by one and scans again, and a turn that
// preempts its job runs a second scan before the job is queued again.
// Results then leave in load order, each held until the sink accepts it;
// no request is taken until the last result of the batch has been accepted.
module round_robin_schedule_simulator #(
    parameter int MAX_JOBS = rrss_pkg::MAX_JOBS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_arrival_time,
    input  logic [15:0] i_burst_time,
    input  logic        i_last_job,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [6:0]  o_job_number,
    output logic [23:0] o_completion_time,
    output logic [23:0] o_turnaround_time,
    output logic [23:0] o_waiting_time,
    output logic        o_last_result
);
    localparam int IW = $clog2(MAX_JOBS);
    localparam int CW = $clog2(MAX_JOBS + 1);

    typedef enum logic [3:0] {
        S_LOAD, S_SCAN, S_SCAN_W, S_SEL, S_POP, S_RUN, S_RUN_W, S_RESCAN, S_RESCAN_W,
        S_PUSH, S_OUT, S_OUT_W, S_HOLD
    } t_state;

    function automatic logic [6:0] JOBNUM(input logic [CW-1:0] idx);
        logic [7:0] v;
        v = 8'(idx) + 8'd1;
        return v[6:0];
    endfunction

    t_state r_state;
    logic [15:0] r_quantum;
    logic [15:0] arr_mem [MAX_JOBS];
    logic [15:0] bur_mem [MAX_JOBS];
    logic [15:0] rem_mem [MAX_JOBS];
    logic [23:0] fin_mem [MAX_JOBS];
    logic [IW-1:0] ring_mem [MAX_JOBS];
    rrss_pkg::t_phase phase_mem [MAX_JOBS];
    logic [IW-1:0] r_head;
    logic [CW-1:0] r_count, r_loaded, r_done, r_idx;
    logic [23:0] r_clock;
    logic [IW-1:0] r_job;
    logic [15:0] r_arr_q, r_bur_q, r_rem_q;
    logic [23:0] r_fin_q;
    logic [IW-1:0] r_ring_q;
    rrss_pkg::t_phase r_phase_q;
    logic        r_fired;

    logic [15:0] slice;
    logic [IW-1:0] tail;
    logic [CW:0]   tail_sum;
    logic [23:0]   tt;
    logic          admit;

    assign slice = (r_quantum == 16'd0) ? 16'd1 : r_quantum;
    assign tail_sum = (CW+1)'(r_head) + (CW+1)'(r_count);
    assign tail = (tail_sum >= (CW+1)'(MAX_JOBS)) ? IW'(tail_sum - (CW+1)'(MAX_JOBS))
                                                  : IW'(tail_sum);
    assign o_cfg_ready = 1'b1;
    assign o_ready = (r_state == S_LOAD);
    assign tt = r_fin_q - {8'd0, r_arr_q};
    assign admit = (r_state == S_SCAN_W || r_state == S_RESCAN_W) && !r_fired
                   && (r_idx < r_loaded) && (r_phase_q == rrss_pkg::PH_WAIT)
                   && ({8'd0, r_arr_q} <= r_clock) && (r_count < CW'(MAX_JOBS));

    always_ff @(posedge i_clk) begin
        r_arr_q   <= arr_mem[r_idx[IW-1:0]];
        r_bur_q   <= bur_mem[r_idx[IW-1:0]];
        r_fin_q   <= fin_mem[r_idx[IW-1:0]];
        r_phase_q <= phase_mem[r_idx[IW-1:0]];
        r_rem_q   <= rem_mem[r_job];
        r_ring_q  <= ring_mem[r_head];
        if (i_valid && o_ready && r_loaded < CW'(MAX_JOBS)) begin
            arr_mem[r_loaded[IW-1:0]] <= i_arrival_time;
            bur_mem[r_loaded[IW-1:0]] <= i_burst_time;
            rem_mem[r_loaded[IW-1:0]] <= i_burst_time;
        end else if (r_state == S_RUN_W) begin
            if ({8'd0, r_rem_q} <= {8'd0, slice}) rem_mem[r_job] <= 16'd0;
            else rem_mem[r_job] <= r_rem_q - slice;
        end
        if (i_valid && o_ready && r_loaded < CW'(MAX_JOBS))
            phase_mem[r_loaded[IW-1:0]] <= rrss_pkg::PH_WAIT;
        else if (admit)
            phase_mem[r_idx[IW-1:0]] <= rrss_pkg::PH_QUEUED;
        else if (r_state == S_RUN_W && r_rem_q <= slice)
            phase_mem[r_job] <= rrss_pkg::PH_DONE;
        if (r_state == S_RUN_W && r_rem_q <= slice)
            fin_mem[r_job] <= r_clock + {8'd0, r_rem_q};
        if (r_fired) ring_mem[tail] <= r_idx[IW-1:0] - IW'(1);
        else if (r_state == S_PUSH) ring_mem[tail] <= r_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_quantum <= rrss_pkg::QUANTUM_RST;
            r_head <= '0; r_count <= '0; r_loaded <= '0; r_done <= '0;
            r_idx <= '0; r_clock <= '0; r_job <= '0; r_fired <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_quantum <= i_cfg_data;
            r_fired <= 1'b0;
            if (r_fired) r_count <= r_count + CW'(1);
            case (r_state)
                S_LOAD: begin
                    if (i_valid) begin
                        if (r_loaded < CW'(MAX_JOBS))
                            r_loaded <= r_loaded + CW'(1);
                        if (i_last_job) begin
                            r_idx <= '0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN, S_RESCAN: begin
                    // address r_idx presented, wait for read data
                    r_state <= (r_state == S_SCAN) ? S_SCAN_W : S_RESCAN_W;
                end
                S_SCAN_W, S_RESCAN_W: begin
                    if (!r_fired && r_idx < r_loaded) begin
                        if (admit)
                            r_fired <= 1'b1;
                        r_idx <= r_idx + CW'(1);
                        r_state <= (r_state == S_SCAN_W) ? S_SCAN : S_RESCAN;
                    end else if (!r_fired) begin
                        r_state <= (r_state == S_SCAN_W) ? S_SEL : S_PUSH;
                    end
                end
                S_SEL: begin
                    if (r_done >= r_loaded) begin
                        r_idx <= '0;
                        r_state <= S_OUT;
                    end else if (r_count == '0) begin
                        r_clock <= r_clock + 24'd1;
                        r_idx <= '0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_POP;
                    end
                end
                S_POP: begin
                    r_job <= r_ring_q;
                    r_head <= (r_head == IW'(MAX_JOBS - 1)) ? '0 : r_head + IW'(1);
                    r_count <= r_count - CW'(1);
                    r_state <= S_RUN;
                end
                S_RUN: r_state <= S_RUN_W;
                S_RUN_W: begin
                    r_idx <= '0;
                    if (r_rem_q <= slice) begin
                        r_clock <= r_clock + {8'd0, r_rem_q};
                        r_done <= r_done + CW'(1);
                        r_state <= (r_done + CW'(1) >= r_loaded) ? S_SEL : S_SCAN;
                    end else begin
                        r_clock <= r_clock + {8'd0, slice};
                        r_state <= S_RESCAN;
                    end
                end
                S_PUSH: begin
                    if (r_count < CW'(MAX_JOBS)) r_count <= r_count + CW'(1);
                    r_idx <= '0;
                    r_state <= S_SCAN;
                end
                S_OUT: r_state <= S_OUT_W;
                S_OUT_W: begin
                    o_valid <= 1'b1;
                    o_job_number <= JOBNUM(r_idx);
                    o_completion_time <= r_fin_q;
                    o_turnaround_time <= tt;
                    o_waiting_time <= tt - {8'd0, r_bur_q};
                    o_last_result <= (r_idx + CW'(1) == r_loaded);
                    r_state <= S_HOLD;
                end
                S_HOLD: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        if (o_last_result) begin
                            r_head <= '0; r_count <= '0; r_loaded <= '0; r_done <= '0;
                            r_clock <= '0; r_idx <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_idx <= r_idx + CW'(1);
                            r_state <= S_OUT;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_JOBS)) else $error("ring count overflow");
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done <= r_loaded) else $error("done exceeds loaded");
    a_ready_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("load during output");
endmodule
